### hw/rtl/pip_pkg.sv
// shared types and constants for the point-in-polygon site search core
// no dependencies; imported by every module of the block
`default_nettype none

package pip_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_SITES      = 16;
	localparam int SLOT_BITS      = 4;
	localparam int SLOT_CMP_BITS  = 9;
	localparam int S_TUSER_BITS   = SLOT_BITS + 2;
	localparam int M_TDATA_BITS   = ((SLOT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic                 fire;
		logic                 vertex_valid;
		logic [SLOT_BITS-1:0] site_slot;
		logic                 last_of_site;
		logic                 last_of_all;
	} pip_ctrl_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_BITS-1:0] hit_slot;
	} pip_result_t;

endpackage

`default_nettype wire

### hw/rtl/point_in_polygon_site_search_core.sv
// point-in-polygon site search core: input register, edge and site logic, result register
// uses pip_pkg and pip_site_state
// result: the transaction with tlast is held in the input register, then its result is loaded into the result register
// throughput: one input transaction per cycle while no run-ending transaction stalls; set by the single edge-test stage
// a run-ending transaction waits in the input register only while a result is not taken
// reset: arst_n clears all handshake and site state; no clearing pass
`default_nettype none

module point_in_polygon_site_search_core
	import pip_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// point_x, point_y, vertex_x, vertex_y
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
	// vertex_valid, site_slot, last_of_site
	input  logic [S_TUSER_BITS-1:0]                  s_axis_tuser,
	input  logic                                     s_axis_tlast,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// hit_slot
	output logic [M_TDATA_BITS-1:0]                  m_axis_tdata,
	// found
	output logic                                     m_axis_tuser
);

	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] px_s1;
	logic signed [COORD_BITS-1:0] py_s1;
	logic signed [COORD_BITS-1:0] vx_s1;
	logic signed [COORD_BITS-1:0] vy_s1;
	logic                         vvalid_s1;
	logic [SLOT_BITS-1:0]         slot_s1;
	logic                         last_site_s1;
	logic                         last_all_s1;

	logic                         out_valid_q;
	pip_result_t                  out_q;

	logic                         s_acc;
	logic                         adv_s1;
	pip_ctrl_t                    ctrl;
	pip_result_t                  result;

	assign adv_s1 = valid_s1 && (!last_all_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			px_s1        <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
			py_s1        <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
			vx_s1        <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
			vy_s1        <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
			vvalid_s1    <= s_axis_tuser[0];
			slot_s1      <= s_axis_tuser[SLOT_BITS:1];
			last_site_s1 <= s_axis_tuser[SLOT_BITS+1];
			last_all_s1  <= s_axis_tlast;
		end
	end

	assign ctrl.fire         = adv_s1;
	assign ctrl.vertex_valid = vvalid_s1;
	assign ctrl.site_slot    = slot_s1;
	assign ctrl.last_of_site = last_site_s1;
	assign ctrl.last_of_all  = last_all_s1;

	pip_site_state #(
		.COORD_BITS(COORD_BITS)
	) u_site (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.point_x (px_s1),
		.point_y (py_s1),
		.vertex_x(vx_s1),
		.vertex_y(vy_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_all_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_all_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_BITS'(out_q.hit_slot);
	assign m_axis_tuser  = out_q.found;

`ifndef SYNTHESIS
	a_run_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_all_s1 |=> m_axis_tvalid)
		else $error("run end did not load the result register");

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> out_valid_q && !m_axis_tready && last_all_s1)
		else $error("input stage stalled without a blocked result");

	a_no_hit_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("hit slot nonzero while nothing found");

	a_mid_run_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !last_all_s1 && !(m_axis_tvalid && !m_axis_tready) |=> !m_axis_tvalid)
		else $error("result appeared without a run end");
`endif

endmodule

`default_nettype wire

### hw/rtl/pip_edge_test.sv
// upward crossing test of one polygon edge against the query point
// exact cross-multiplication; uses pip_pkg
`default_nettype none

module pip_edge_test
	import pip_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         enable,
	input  logic signed [COORD_BITS-1:0] xa,
	input  logic signed [COORD_BITS-1:0] ya,
	input  logic signed [COORD_BITS-1:0] xb,
	input  logic signed [COORD_BITS-1:0] yb,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	output logic                         crosses
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [COORD_BITS-1:0] x_lo;
	logic signed [COORD_BITS-1:0] x_hi;
	logic                         span_ok;
	logic signed [DW-1:0]         dx;
	logic signed [DW-1:0]         dy;
	logic signed [DW-1:0]         qx;
	logic signed [DW-1:0]         qy;
	logic signed [PW-1:0]         prod_a;
	logic signed [PW-1:0]         prod_b;
	logic                         below;

	assign x_lo = (xa < xb) ? xa : xb;
	assign x_hi = (xa < xb) ? xb : xa;
	assign span_ok = (px > x_lo) && (px <= x_hi) && ((py < ya) || (py <= yb));

	assign dx = $signed({xb[COORD_BITS-1], xb}) - $signed({xa[COORD_BITS-1], xa});
	assign dy = $signed({yb[COORD_BITS-1], yb}) - $signed({ya[COORD_BITS-1], ya});
	assign qx = $signed({px[COORD_BITS-1], px}) - $signed({xa[COORD_BITS-1], xa});
	assign qy = $signed({py[COORD_BITS-1], py}) - $signed({ya[COORD_BITS-1], ya});

	assign prod_a = PW'(qy) * PW'(dx);
	assign prod_b = PW'(dy) * PW'(qx);

	// sign of dx flips the sense of the line test
	assign below = dx[DW-1] ? (prod_b <= prod_a) : (prod_a <= prod_b);

	assign crosses = enable && span_ok && below;

endmodule

`default_nettype wire

### hw/rtl/pip_site_state.sv
// per-site vertex tracking, crossing parity and first-match recording
// uses pip_pkg and pip_edge_test
`default_nettype none

module pip_site_state
	import pip_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pip_ctrl_t                    ctrl,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	output pip_result_t                  result
);

	logic signed [COORD_BITS-1:0] first_x_q;
	logic signed [COORD_BITS-1:0] first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q;
	logic signed [COORD_BITS-1:0] prev_y_q;
	logic                         have_q;
	logic                         parity_q;
	logic                         seen_q;
	logic [SLOT_BITS-1:0]         slot_q;

	logic                         close_site;
	logic                         en_edge;
	logic                         en_close;
	logic                         cross_edge;
	logic                         cross_close;
	logic signed [COORD_BITS-1:0] ca_x;
	logic signed [COORD_BITS-1:0] ca_y;
	logic signed [COORD_BITS-1:0] cb_x;
	logic signed [COORD_BITS-1:0] cb_y;
	logic                         parity_next;
	logic                         match_now;
	logic                         seen_next;
	logic [SLOT_BITS-1:0]         slot_next;

	assign close_site = ctrl.last_of_site || ctrl.last_of_all;
	assign en_edge    = ctrl.vertex_valid && have_q;
	assign en_close   = close_site && (ctrl.vertex_valid || have_q);

	// closing edge runs from the newest vertex back to the first one
	assign ca_x = ctrl.vertex_valid ? vertex_x : prev_x_q;
	assign ca_y = ctrl.vertex_valid ? vertex_y : prev_y_q;
	assign cb_x = (ctrl.vertex_valid && !have_q) ? vertex_x : first_x_q;
	assign cb_y = (ctrl.vertex_valid && !have_q) ? vertex_y : first_y_q;

	pip_edge_test #(
		.COORD_BITS(COORD_BITS)
	) u_edge (
		.enable (en_edge),
		.xa     (prev_x_q),
		.ya     (prev_y_q),
		.xb     (vertex_x),
		.yb     (vertex_y),
		.px     (point_x),
		.py     (point_y),
		.crosses(cross_edge)
	);

	pip_edge_test #(
		.COORD_BITS(COORD_BITS)
	) u_close (
		.enable (en_close),
		.xa     (ca_x),
		.ya     (ca_y),
		.xb     (cb_x),
		.yb     (cb_y),
		.px     (point_x),
		.py     (point_y),
		.crosses(cross_close)
	);

	assign parity_next = parity_q ^ cross_edge ^ cross_close;
	assign match_now   = close_site && parity_next && !seen_q &&
		(SLOT_CMP_BITS'(ctrl.site_slot) < SLOT_CMP_BITS'(MAX_SITES));
	assign seen_next   = seen_q || match_now;
	assign slot_next   = match_now ? ctrl.site_slot : slot_q;

	assign result.found    = seen_next;
	assign result.hit_slot = seen_next ? slot_next : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			parity_q <= 1'b0;
			seen_q   <= 1'b0;
			slot_q   <= '0;
		end else if (ctrl.fire) begin
			if (close_site) begin
				have_q   <= 1'b0;
				parity_q <= 1'b0;
			end else begin
				have_q   <= have_q || ctrl.vertex_valid;
				parity_q <= parity_next;
			end
			if (ctrl.last_of_all) begin
				seen_q <= 1'b0;
				slot_q <= '0;
			end else begin
				seen_q <= seen_next;
				slot_q <= slot_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.vertex_valid && !close_site) begin
			prev_x_q <= vertex_x;
			prev_y_q <= vertex_y;
			if (!have_q) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
			end
		end
	end

endmodule

`default_nettype wire
